### hw/rtl/lipr_pkg.sv
// ----------------------------------------------------------------------------
// lipr_pkg
// shared types, constants and helpers for the learned index partition range
// ----------------------------------------------------------------------------
`default_nettype none

package lipr_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int INDEX_BITS_DEF = 16;

    localparam int BIT_COUNT_W  = 6;
    localparam int WORD_W       = 64;
    localparam int PART_W       = 16;
    localparam int PRED_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int S_USER_W     = 4;
    localparam int OUT_FIELDS_W = 3 * PART_W + 2;
    localparam int M_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_RST  = 6'd16;
    localparam logic [WORD_W-1:0]      Z_BASE_RST     = 64'd0;
    localparam logic [WORD_W-1:0]      SCALE_RST      = 64'h0001_0000_0000_0000;
    localparam logic [PART_W-1:0]      PART_COUNT_RST = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_COUNT  = 2'd0,
        CFG_Z_BASE     = 2'd1,
        CFG_SCALE      = 2'd2,
        CFG_PART_COUNT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        REQ_LEFT      = 3'd0,
        REQ_RIGHT     = 3'd1,
        REQ_SAME      = 3'd2,
        REQ_BELOW     = 3'd3,
        REQ_ABOVE     = 3'd4,
        REQ_CONTAINED = 3'd5
    } req_type_t;

    typedef struct packed {
        req_type_t req_type;
        logic      first_key;
        logic      last_key;
    } key_ctrl_t;

    typedef struct packed {
        logic              bad_strategy;
        logic [PART_W-1:0] node_count;
        logic              range_empty;
        logic [PART_W-1:0] last_part;
        logic [PART_W-1:0] first_part;
    } range_result_t;

    // highest partition index, a count of zero acts as one
    function automatic logic [PART_W-1:0] limit_of(input logic [PART_W-1:0] count);
        return (count == '0) ? '0 : count - PART_W'(1);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lipr_predict.sv
// ----------------------------------------------------------------------------
// lipr_predict
// morton code and linear model prediction, three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module lipr_predict import lipr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   advance,
    input  wire logic [COORD_BITS-1:0]  coord_x,
    input  wire logic [COORD_BITS-1:0]  coord_y,
    input  wire logic [BIT_COUNT_W-1:0] bit_count,
    input  wire logic [WORD_W-1:0]      z_base,
    input  wire logic [WORD_W-1:0]      scale,
    input  wire logic [PART_W-1:0]      limit,
    output logic      [PRED_W-1:0]      pred
);

    localparam int SHW = $clog2(COORD_BITS + 1);

    logic [BIT_COUNT_W-1:0] n_eff;
    logic [SHW-1:0]         shift;
    logic [COORD_BITS-1:0]  xs;
    logic [COORD_BITS-1:0]  ys;
    logic [WORD_W-1:0]      zcode;
    logic [WORD_W-1:0]      d_next;
    logic [WORD_W-1:0]      d_reg;

    logic [WORD_W-1:0] p00_next, p01_next, p10_next, p11_next;
    logic [WORD_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;

    logic [33:0]       mid;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] quot;
    logic [PRED_W-1:0] pred_next;
    logic [PRED_W-1:0] pred_reg;

    // morton interleave of the top bits, offset by the model base
    always_comb begin
        n_eff = (bit_count > BIT_COUNT_W'(COORD_BITS)) ? BIT_COUNT_W'(COORD_BITS) : bit_count;
        shift = SHW'(COORD_BITS) - SHW'(n_eff);
        xs    = coord_x >> shift;
        ys    = coord_y >> shift;
        zcode = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            if (i < int'(n_eff)) begin
                zcode[2*i]   = xs[i];
                zcode[2*i+1] = ys[i];
            end
        end
        d_next = (zcode > z_base) ? zcode - z_base : '0;
    end

    // 64x64 product as four 32x32 partial products
    assign p00_next = d_reg[31:0]  * scale[31:0];
    assign p01_next = d_reg[31:0]  * scale[63:32];
    assign p10_next = d_reg[63:32] * scale[31:0];
    assign p11_next = d_reg[63:32] * scale[63:32];

    always_comb begin
        mid  = 34'(p00_reg[63:32]) + 34'(p01_reg[31:0]) + 34'(p10_reg[31:0]);
        hi   = p11_reg + WORD_W'(p01_reg[63:32]) + WORD_W'(p10_reg[63:32])
             + WORD_W'(mid[33:32]);
        quot = {hi[47:0], mid[31:16]};
        if (hi[63:48] != '0 || quot > WORD_W'(limit)) begin
            pred_next = limit;
        end else begin
            pred_next = quot[PRED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            d_reg    <= d_next;
            p00_reg  <= p00_next;
            p01_reg  <= p01_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            pred_reg <= pred_next;
        end
    end

    assign pred = pred_reg;

endmodule

`default_nettype wire

### hw/rtl/lipr_bounds.sv
// ----------------------------------------------------------------------------
// lipr_bounds
// query bound tracking and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lipr_bounds import lipr_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic              item_valid,
    input  wire key_ctrl_t         ctrl,
    input  wire logic [PRED_W-1:0] pred_point,
    input  wire logic [PRED_W-1:0] pred_box,
    input  wire logic [PART_W-1:0] limit,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output range_result_t          result
);

    localparam int CW = (INDEX_BITS > PRED_W) ? INDEX_BITS : PRED_W;

    logic [INDEX_BITS-1:0] low_reg, low_next;
    logic [INDEX_BITS-1:0] high_reg, high_next;
    logic                  stopped_reg, stopped_next;
    logic                  error_reg, error_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    range_result_t         res_reg, res_next;

    logic [INDEX_BITS-1:0] start_high;
    logic [INDEX_BITS-1:0] cur_low, cur_high;
    logic                  cur_stop, cur_err;
    logic [INDEX_BITS-1:0] upd_low, upd_high;
    logic                  upd_stop, upd_err;
    logic                  empty;
    logic [CW-1:0]         span;
    logic                  take;

    assign take       = advance && item_valid;
    assign start_high = INDEX_BITS'(limit);

    always_comb begin
        cur_low  = ctrl.first_key ? '0 : low_reg;
        cur_high = ctrl.first_key ? start_high : high_reg;
        cur_stop = ctrl.first_key ? 1'b0 : stopped_reg;
        cur_err  = ctrl.first_key ? 1'b0 : error_reg;

        upd_low  = cur_low;
        upd_high = cur_high;
        upd_err  = cur_err;
        upd_stop = cur_stop;
        if (!cur_stop) begin
            unique case (ctrl.req_type)
                REQ_LEFT, REQ_BELOW: begin
                    upd_high = INDEX_BITS'(pred_point);
                end
                REQ_RIGHT, REQ_ABOVE: begin
                    upd_low = INDEX_BITS'(pred_point);
                end
                REQ_SAME: begin
                end
                REQ_CONTAINED: begin
                    if (CW'(pred_point) > CW'(cur_low)) begin
                        upd_low = INDEX_BITS'(pred_point);
                    end
                    if (CW'(pred_box) < CW'(cur_high)) begin
                        upd_high = INDEX_BITS'(pred_box);
                    end
                end
                default: begin
                    upd_err = 1'b1;
                end
            endcase
            upd_stop = (upd_high < upd_low);
        end

        empty = (upd_high < upd_low);
        span  = empty ? '0 : CW'(upd_high) - CW'(upd_low) + CW'(1);

        res_next.first_part   = PART_W'(upd_low);
        res_next.last_part    = PART_W'(upd_high);
        res_next.range_empty  = empty;
        res_next.node_count   = PART_W'(span);
        res_next.bad_strategy = upd_err;

        // a finished query reloads the bounds at once
        if (take && ctrl.last_key) begin
            low_next     = '0;
            high_next    = start_high;
            stopped_next = 1'b0;
            error_next   = 1'b0;
        end else if (take) begin
            low_next     = upd_low;
            high_next    = upd_high;
            stopped_next = upd_stop;
            error_next   = upd_err;
        end else begin
            low_next     = low_reg;
            high_next    = high_reg;
            stopped_next = stopped_reg;
            error_next   = error_reg;
        end

        if (take && ctrl.last_key) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg      <= '0;
            high_reg     <= INDEX_BITS'(limit_of(PART_COUNT_RST));
            stopped_reg  <= 1'b0;
            error_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            low_reg      <= low_next;
            high_reg     <= high_next;
            stopped_reg  <= stopped_next;
            error_reg    <= error_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (take && ctrl.last_key) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign result   = res_reg;

`ifndef SYNTHESIS
    a_stop_matches_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg == (high_reg < low_reg))
        else $error("stop flag out of step with bounds");

    a_reload_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && ctrl.last_key) |=> (low_reg == '0 && !stopped_reg && !error_reg
                                     && m_tvalid_reg))
        else $error("query state not reloaded after result");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(take && ctrl.last_key))
        else $error("result without a last key");
`endif

endmodule

`default_nettype wire

### hw/rtl/learned_index_partition_range.sv
// ----------------------------------------------------------------------------
// learned_index_partition_range
// partition range finder for a morton code linear model spatial index
// ----------------------------------------------------------------------------
// register path: input, difference, products, prediction, then result and m_tvalid
// throughput: one key per cycle; the whole pipeline holds while a result waits
// the 64x64 model multiply is split into four 32x32 partial products, one stage
// reset (aresetn low, synchronous): pipeline valid flags and query state cleared,
// configuration registers back to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module learned_index_partition_range import lipr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]                   cfg_index,
    input  wire logic [WORD_W-1:0]                      cfg_wdata,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // point_x, point_y, box_high_x, box_high_y, zero pad
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // req_type, first_key
    input  wire logic [S_USER_W-1:0]                    s_tuser,
    input  wire logic                                   s_tlast,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // first_part, last_part, range_empty, node_count, bad_strategy, zero pad
    output logic [M_DATA_W-1:0]                         m_tdata
);

    logic [BIT_COUNT_W-1:0] bit_count_reg;
    logic [WORD_W-1:0]      z_base_reg;
    logic [WORD_W-1:0]      scale_reg;
    logic [PART_W-1:0]      part_count_reg;
    logic [PART_W-1:0]      limit;

    logic                  advance;
    logic                  v0_reg, v1_reg, v2_reg, v3_reg;
    key_ctrl_t             ctrl0_reg, ctrl1_reg, ctrl2_reg, ctrl3_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg, hx_reg, hy_reg;
    logic [PRED_W-1:0]     pred_point, pred_box;
    range_result_t         result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg  <= BIT_COUNT_RST;
            z_base_reg     <= Z_BASE_RST;
            scale_reg      <= SCALE_RST;
            part_count_reg <= PART_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BIT_COUNT:  bit_count_reg  <= cfg_wdata[BIT_COUNT_W-1:0];
                CFG_Z_BASE:     z_base_reg     <= cfg_wdata;
                CFG_SCALE:      scale_reg      <= cfg_wdata;
                CFG_PART_COUNT: part_count_reg <= cfg_wdata[PART_W-1:0];
            endcase
        end
    end

    assign limit    = limit_of(part_count_reg);
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (advance) begin
            ctrl0_reg.req_type  <= req_type_t'(s_tuser[2:0]);
            ctrl0_reg.first_key <= s_tuser[3];
            ctrl0_reg.last_key  <= s_tlast;
            px_reg              <= s_tdata[COORD_BITS-1:0];
            py_reg              <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            hx_reg              <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            hy_reg              <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
            ctrl1_reg           <= ctrl0_reg;
            ctrl2_reg           <= ctrl1_reg;
            ctrl3_reg           <= ctrl2_reg;
        end
    end

    lipr_predict #(
        .COORD_BITS (COORD_BITS)
    ) u_pred_point (
        .aclk      (aclk),
        .advance   (advance),
        .coord_x   (px_reg),
        .coord_y   (py_reg),
        .bit_count (bit_count_reg),
        .z_base    (z_base_reg),
        .scale     (scale_reg),
        .limit     (limit),
        .pred      (pred_point)
    );

    lipr_predict #(
        .COORD_BITS (COORD_BITS)
    ) u_pred_box (
        .aclk      (aclk),
        .advance   (advance),
        .coord_x   (hx_reg),
        .coord_y   (hy_reg),
        .bit_count (bit_count_reg),
        .z_base    (z_base_reg),
        .scale     (scale_reg),
        .limit     (limit),
        .pred      (pred_box)
    );

    lipr_bounds #(
        .INDEX_BITS (INDEX_BITS)
    ) u_bounds (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item_valid (v3_reg),
        .ctrl       (ctrl3_reg),
        .pred_point (pred_point),
        .pred_box   (pred_box),
        .limit      (limit),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .result     (result)
    );

    assign m_tdata = M_DATA_W'(result);

endmodule

`default_nettype wire
